>>> rtl/ssp_pkg.sv
`default_nettype none
package ssp_pkg;

	// field widths
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;
	localparam int SCR_W   = 13;
	localparam int POS_W   = 16;
	localparam int VEC_W   = 16;
	localparam int DIFF_W  = 17;   // sprite minus player, signed
	localparam int SQ_W    = 32;   // one squared difference
	localparam int DIST_W  = 33;
	localparam int PROD_W  = 33;   // vector times difference, signed
	localparam int NUM_W   = 34;   // transform numerator, signed
	localparam int TQ_W    = 47;   // transform quotient magnitude bits
	localparam int DET_W   = 32;   // determinant magnitude bits
	localparam int TY_W    = 48;   // signed tx / ty
	localparam int SUM_W   = 49;   // signed tx + ty
	localparam int CNUM_W  = 60;   // (W/2) * |tx + ty|
	localparam int PQ_W    = 21;   // column and size quotient bits
	localparam int PR_W    = 47;   // positive ty magnitude bits
	localparam int COL_W   = 23;   // column, pre-saturated
	localparam int SIZE_W  = 15;
	localparam int OUT_W   = 16;

	// column stand-in once the quotient is known to reach 2^PQ_W
	localparam logic signed [COL_W-1:0] COL_SAT = COL_W'(1) <<< PQ_W;

	typedef enum logic [IDX_W-1:0] {
		REG_SCREEN_W = 3'd0,
		REG_SCREEN_H = 3'd1,
		REG_PLAYER_X = 3'd2,
		REG_PLAYER_Y = 3'd3,
		REG_DIR_X    = 3'd4,
		REG_DIR_Y    = 3'd5,
		REG_PLANE_X  = 3'd6,
		REG_PLANE_Y  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [SCR_W-1:0]        screen_w;
		logic [SCR_W-1:0]        screen_h;
		logic [POS_W-1:0]        player_x;
		logic [POS_W-1:0]        player_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
	} cam_cfg_t;

	typedef struct packed {
		logic [DET_W-1:0] mag;
		logic             neg;
		logic             zero;
	} det_info_t;

	// sideband that rides along the transform divider
	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] dsq;
		logic              nx_neg;
		logic              ny_neg;
	} tside_t;

	// projection results handed to the output stages
	typedef struct packed {
		logic                   valid;
		logic [DIST_W-1:0]      dsq;
		logic                   behind;
		logic signed [TY_W-1:0] ty;
		logic                   col_neg;
		logic                   col_ovf;
		logic [PQ_W-1:0]        col_mag;
		logic [PQ_W-1:0]        size_q;
	} pside_t;

endpackage
`default_nettype wire

>>> rtl/ssp_front.sv
`default_nettype none
module ssp_front import ssp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire logic [POS_W-1:0] sprite_x,
	input  wire logic [POS_W-1:0] sprite_y,
	input  wire cam_cfg_t         cfg,
	output tside_t                o_side,
	output logic [TQ_W-1:0]       o_nx,
	output logic [TQ_W-1:0]       o_ny
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;
	logic signed [PROD_W-1:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic [DIST_W-1:0] dist_s3, dist_s4;
	logic signed [NUM_W-1:0] nx_s3, ny_s3;
	logic [TQ_W-1:0] nx_s4, ny_s4;
	logic nxn_s4, nyn_s4;

	logic signed [2*DIFF_W-1:0] sqx, sqy;
	logic signed [NUM_W-1:0] nx_abs, ny_abs;

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;
	assign nx_abs = nx_s3[NUM_W-1] ? -nx_s3 : nx_s3;
	assign ny_abs = ny_s3[NUM_W-1] ? -ny_s3 : ny_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// differences, products, sums, magnitudes scaled by 2^14
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= $signed({1'b0, sprite_x}) - $signed({1'b0, cfg.player_x});
			dy_s1  <= $signed({1'b0, sprite_y}) - $signed({1'b0, cfg.player_y});
			sqx_s2 <= sqx[SQ_W-1:0];
			sqy_s2 <= sqy[SQ_W-1:0];
			p1_s2  <= cfg.dir_y * dx_s1;
			p2_s2  <= cfg.dir_x * dy_s1;
			p3_s2  <= cfg.plane_x * dy_s1;
			p4_s2  <= cfg.plane_y * dx_s1;
			dist_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			nx_s3  <= $signed({p1_s2[PROD_W-1], p1_s2}) - $signed({p2_s2[PROD_W-1], p2_s2});
			ny_s3  <= $signed({p3_s2[PROD_W-1], p3_s2}) - $signed({p4_s2[PROD_W-1], p4_s2});
			dist_s4 <= dist_s3;
			nxn_s4 <= nx_s3[NUM_W-1];
			nyn_s4 <= ny_s3[NUM_W-1];
			nx_s4  <= {nx_abs[NUM_W-2:0], 14'b0};
			ny_s4  <= {ny_abs[NUM_W-2:0], 14'b0};
		end
	end

	assign o_side = '{valid: v_s4, dsq: dist_s4, nx_neg: nxn_s4, ny_neg: nyn_s4};
	assign o_nx = nx_s4;
	assign o_ny = ny_s4;

endmodule
`default_nettype wire

>>> rtl/ssp_tdiv.sv
`default_nettype none
module ssp_tdiv import ssp_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire det_info_t       det,
	input  wire tside_t          i_side,
	input  wire logic [TQ_W-1:0] i_nx,
	input  wire logic [TQ_W-1:0] i_ny,
	output tside_t               o_side,
	output logic [TQ_W-1:0]      o_qx,
	output logic [TQ_W-1:0]      o_qy
);

	// one restoring step: remainder and numerator shift left, quotient bit enters low
	function automatic logic [DET_W+TQ_W-1:0] tstep(
		input logic [DET_W-1:0] r,
		input logic [TQ_W-1:0]  n,
		input logic [DET_W-1:0] d
	);
		logic [DET_W:0] t;
		logic ge;
		t  = {r, n[TQ_W-1]};
		ge = (t >= {1'b0, d});
		if (ge) begin
			t = t - {1'b0, d};
		end
		return {t[DET_W-1:0], n[TQ_W-2:0], ge};
	endfunction

	tside_t           side_sk [TQ_W];
	logic [DET_W-1:0] rx_sk [TQ_W];
	logic [DET_W-1:0] ry_sk [TQ_W];
	logic [TQ_W-1:0]  qx_sk [TQ_W];
	logic [TQ_W-1:0]  qy_sk [TQ_W];

	// sideband and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TQ_W; k++) begin
				side_sk[k] <= '0;
			end
		end else if (adv) begin
			side_sk[0] <= i_side;
			for (int k = 1; k < TQ_W; k++) begin
				side_sk[k] <= side_sk[k-1];
			end
		end
	end

	// one quotient bit per stage, both lanes share |det|
	always_ff @(posedge clk) begin
		if (adv) begin
			{rx_sk[0], qx_sk[0]} <= tstep('0, i_nx, det.mag);
			{ry_sk[0], qy_sk[0]} <= tstep('0, i_ny, det.mag);
			for (int k = 1; k < TQ_W; k++) begin
				{rx_sk[k], qx_sk[k]} <= tstep(rx_sk[k-1], qx_sk[k-1], det.mag);
				{ry_sk[k], qy_sk[k]} <= tstep(ry_sk[k-1], qy_sk[k-1], det.mag);
			end
		end
	end

	assign o_side = side_sk[TQ_W-1];
	assign o_qx   = qx_sk[TQ_W-1];
	assign o_qy   = qy_sk[TQ_W-1];

endmodule
`default_nettype wire

>>> rtl/ssp_pdiv.sv
`default_nettype none
module ssp_pdiv import ssp_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire cam_cfg_t        cfg,
	input  wire det_info_t       det,
	input  wire tside_t          i_side,
	input  wire logic [TQ_W-1:0] i_qx,
	input  wire logic [TQ_W-1:0] i_qy,
	output pside_t               o_res
);

	typedef struct packed {
		logic                   valid;
		logic [DIST_W-1:0]      dsq;
		logic                   behind;
		logic signed [TY_W-1:0] ty;
		logic                   sneg;
		logic                   ovf;
	} pmid_t;

	// restoring step with the divisor ty
	function automatic logic [PR_W+PQ_W-1:0] pstep(
		input logic [PR_W-1:0] r,
		input logic [PQ_W-1:0] n,
		input logic [PR_W-1:0] d
	);
		logic [PR_W:0] t;
		logic ge;
		t  = {r, n[PQ_W-1]};
		ge = (t >= {1'b0, d});
		if (ge) begin
			t = t - {1'b0, d};
		end
		return {t[PR_W-1:0], n[PQ_W-2:0], ge};
	endfunction

	tside_t side_s1;
	logic signed [TY_W-1:0] tx_s1, ty_s1;
	logic signed [SUM_W-1:0] sum_s2;
	logic [SUM_W-2:0] smag_s3;
	logic [35:0] lo_s4, hi_s4;
	logic [CNUM_W-1:0] cnum_s5;
	logic [PR_W-1:0] rc_s6, rs_s6;
	logic [PQ_W-1:0] nc_s6, ns_s6;
	pmid_t m_s2, m_s3, m_s4, m_s5, m_s6;

	pmid_t           m_sk [PQ_W];
	logic [PR_W-1:0] rc_sk [PQ_W];
	logic [PR_W-1:0] rs_sk [PQ_W];
	logic [PQ_W-1:0] qc_sk [PQ_W];
	logic [PQ_W-1:0] qs_sk [PQ_W];

	logic signed [TY_W-1:0] tx_d, ty_d;
	logic signed [SUM_W-1:0] sabs;
	logic [SCR_W-2:0] half_w;
	logic ovf_d;
	pmid_t m2_d, m3_d, m6_d;

	// signed transform, zero for a singular camera
	always_comb begin
		tx_d = (i_side.nx_neg ^ det.neg) ? -$signed({1'b0, i_qx}) : $signed({1'b0, i_qx});
		ty_d = (i_side.ny_neg ^ det.neg) ? -$signed({1'b0, i_qy}) : $signed({1'b0, i_qy});
		if (det.zero) begin
			tx_d = '0;
			ty_d = '0;
		end
	end

	assign half_w = cfg.screen_w[SCR_W-1:1];
	assign sabs   = sum_s2[SUM_W-1] ? -sum_s2 : sum_s2;
	assign ovf_d  = {{(PR_W-(CNUM_W-PQ_W)){1'b0}}, cnum_s5[CNUM_W-1:PQ_W]} >= m_s5.ty[PR_W-1:0];

	always_comb begin
		m2_d = '{valid: side_s1.valid, dsq: side_s1.dsq,
			behind: ty_s1[TY_W-1] | (ty_s1 == '0), ty: ty_s1, sneg: 1'b0, ovf: 1'b0};
		m3_d = m_s2;
		m3_d.sneg = sum_s2[SUM_W-1];
		m6_d = m_s5;
		m6_d.ovf = ovf_d;
	end

	// valid and sideband
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			m_s2 <= '0;
			m_s3 <= '0;
			m_s4 <= '0;
			m_s5 <= '0;
			m_s6 <= '0;
			for (int k = 0; k < PQ_W; k++) begin
				m_sk[k] <= '0;
			end
		end else if (adv) begin
			side_s1 <= i_side;
			m_s2 <= m2_d;
			m_s3 <= m3_d;
			m_s4 <= m_s3;
			m_s5 <= m_s4;
			m_s6 <= m6_d;
			m_sk[0] <= m_s6;
			for (int k = 1; k < PQ_W; k++) begin
				m_sk[k] <= m_sk[k-1];
			end
		end
	end

	// column numerator, overflow check, then the two quotient lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s1   <= tx_d;
			ty_s1   <= ty_d;
			sum_s2  <= $signed({tx_s1[TY_W-1], tx_s1}) + $signed({ty_s1[TY_W-1], ty_s1});
			smag_s3 <= sabs[SUM_W-2:0];
			lo_s4   <= half_w * smag_s3[23:0];
			hi_s4   <= half_w * smag_s3[SUM_W-2:24];
			cnum_s5 <= {hi_s4, 24'b0} + {24'b0, lo_s4};
			rc_s6   <= {{(PR_W-(CNUM_W-PQ_W)){1'b0}}, cnum_s5[CNUM_W-1:PQ_W]};
			nc_s6   <= cnum_s5[PQ_W-1:0];
			rs_s6   <= '0;
			ns_s6   <= {cfg.screen_h, 8'b0};
			{rc_sk[0], qc_sk[0]} <= pstep(rc_s6, nc_s6, m_s6.ty[PR_W-1:0]);
			{rs_sk[0], qs_sk[0]} <= pstep(rs_s6, ns_s6, m_s6.ty[PR_W-1:0]);
			for (int k = 1; k < PQ_W; k++) begin
				{rc_sk[k], qc_sk[k]} <= pstep(rc_sk[k-1], qc_sk[k-1], m_sk[k-1].ty[PR_W-1:0]);
				{rs_sk[k], qs_sk[k]} <= pstep(rs_sk[k-1], qs_sk[k-1], m_sk[k-1].ty[PR_W-1:0]);
			end
		end
	end

	assign o_res = '{valid: m_sk[PQ_W-1].valid, dsq: m_sk[PQ_W-1].dsq,
		behind: m_sk[PQ_W-1].behind, ty: m_sk[PQ_W-1].ty,
		col_neg: m_sk[PQ_W-1].sneg, col_ovf: m_sk[PQ_W-1].ovf,
		col_mag: qc_sk[PQ_W-1], size_q: qs_sk[PQ_W-1]};

endmodule
`default_nettype wire

>>> rtl/sprite_screen_projection.sv
// Sprite projection through a register-held raycaster camera.
// Throughput: one item per cycle; a stall on the output holds the whole pipeline.
// The determinant is re-registered from the camera registers: products, then difference, then sign and magnitude.
// Reset: camera registers return to their defaults and all valid bits clear.
`default_nettype none
module sprite_screen_projection import ssp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [POS_W-1:0]  sprite_x,
	input  wire logic [POS_W-1:0]  sprite_y,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DIST_W-1:0]      dist_sq,
	output logic signed [OUT_W-1:0] depth,
	output logic                   behind_camera,
	output logic signed [OUT_W-1:0] screen_col,
	output logic [SIZE_W-1:0]      sprite_size,
	output logic [SIZE_W-1:0]      draw_start_x,
	output logic signed [OUT_W-1:0] draw_end_x,
	output logic [SIZE_W-1:0]      draw_start_y,
	output logic signed [OUT_W-1:0] draw_end_y,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data
);

	cam_cfg_t cfg_q;
	logic signed [2*VEC_W-1:0] dprod_a_q, dprod_b_q;
	logic signed [2*VEC_W:0] det_q;
	det_info_t det_info_q;
	logic adv;

	tside_t f_side, t_side;
	logic [TQ_W-1:0] f_nx, f_ny, t_qx, t_qy;
	pside_t p_res;

	logic v_s1;
	logic [DIST_W-1:0] dist_s1;
	logic behind_s1;
	logic signed [TY_W-1:0] ty_s1;
	logic signed [COL_W-1:0] col_s1;
	logic [SIZE_W-1:0] size_s1;

	logic out_valid_q;
	logic [DIST_W-1:0] dist_q;
	logic signed [OUT_W-1:0] depth_q, col_q, ex_q, ey_q;
	logic behind_q;
	logic [SIZE_W-1:0] size_q, sx_q, sy_q;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;

	// camera registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{screen_w: 13'd640, screen_h: 13'd480, player_x: '0, player_y: '0,
				dir_x: 16'sd16384, dir_y: '0, plane_x: '0, plane_y: 16'sd10813};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCREEN_W: cfg_q.screen_w <= cfg_data[SCR_W-1:0];
				REG_SCREEN_H: cfg_q.screen_h <= cfg_data[SCR_W-1:0];
				REG_PLAYER_X: cfg_q.player_x <= cfg_data;
				REG_PLAYER_Y: cfg_q.player_y <= cfg_data;
				REG_DIR_X:    cfg_q.dir_x    <= $signed(cfg_data);
				REG_DIR_Y:    cfg_q.dir_y    <= $signed(cfg_data);
				REG_PLANE_X:  cfg_q.plane_x  <= $signed(cfg_data);
				REG_PLANE_Y:  cfg_q.plane_y  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// determinant, sign and magnitude, free running
	always_ff @(posedge clk) begin
		dprod_a_q <= cfg_q.plane_x * cfg_q.dir_y;
		dprod_b_q <= cfg_q.dir_x * cfg_q.plane_y;
		det_q <= $signed({dprod_a_q[2*VEC_W-1], dprod_a_q})
			- $signed({dprod_b_q[2*VEC_W-1], dprod_b_q});
		det_info_q.neg  <= det_q[2*VEC_W];
		det_info_q.zero <= (det_q == '0);
		det_info_q.mag  <= det_q[2*VEC_W] ? DET_W'(-det_q) : det_q[DET_W-1:0];
	end

	ssp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.sprite_x (sprite_x),
		.sprite_y (sprite_y),
		.cfg      (cfg_q),
		.o_side   (f_side),
		.o_nx     (f_nx),
		.o_ny     (f_ny)
	);

	ssp_tdiv u_tdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.det    (det_info_q),
		.i_side (f_side),
		.i_nx   (f_nx),
		.i_ny   (f_ny),
		.o_side (t_side),
		.o_qx   (t_qx),
		.o_qy   (t_qy)
	);

	ssp_pdiv u_pdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.det    (det_info_q),
		.i_side (t_side),
		.i_qx   (t_qx),
		.i_qy   (t_qy),
		.o_res  (p_res)
	);

	// signed column and saturated size
	logic signed [COL_W-1:0] col_d;
	always_comb begin
		if (p_res.col_ovf) begin
			col_d = p_res.col_neg ? -COL_SAT : COL_SAT;
		end else begin
			col_d = p_res.col_neg ? -$signed({2'b0, p_res.col_mag})
				: $signed({2'b0, p_res.col_mag});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= p_res.valid;
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s1   <= p_res.dsq;
			behind_s1 <= p_res.behind;
			ty_s1     <= p_res.ty;
			col_s1    <= col_d;
			size_s1   <= (p_res.size_q > PQ_W'(32767)) ? SIZE_W'(32767)
				: p_res.size_q[SIZE_W-1:0];
		end
	end

	// draw rectangle and clamps
	logic [SIZE_W-2:0] half;
	logic [SCR_W-2:0] half_h;
	logic signed [COL_W:0] sx_w, ex_w, w_ext;
	logic signed [OUT_W-1:0] sy_w, ey_w, h_ext;
	logic [SIZE_W-1:0] sx_d, sy_d;
	logic signed [OUT_W-1:0] ex_d, ey_d, col_o, depth_d;

	always_comb begin
		half   = size_s1[SIZE_W-1:1];
		half_h = cfg_q.screen_h[SCR_W-1:1];
		w_ext  = $signed({{(COL_W+1-SCR_W){1'b0}}, cfg_q.screen_w});
		h_ext  = $signed({{(OUT_W-SCR_W){1'b0}}, cfg_q.screen_h});
		sx_w   = $signed({col_s1[COL_W-1], col_s1}) - $signed({{(COL_W+2-SIZE_W){1'b0}}, half});
		ex_w   = $signed({col_s1[COL_W-1], col_s1}) + $signed({{(COL_W+2-SIZE_W){1'b0}}, half});
		if (ex_w >= w_ext) begin
			ex_w = w_ext - 24'sd1;
		end
		sy_w = $signed({{(OUT_W-SCR_W+1){1'b0}}, half_h}) - $signed({2'b0, half});
		ey_w = $signed({{(OUT_W-SCR_W+1){1'b0}}, half_h}) + $signed({2'b0, half});
		if (ey_w >= h_ext) begin
			ey_w = h_ext - 16'sd1;
		end

		if (sx_w < 24'sd0) begin
			sx_d = '0;
		end else if (sx_w > 24'sd32767) begin
			sx_d = SIZE_W'(32767);
		end else begin
			sx_d = sx_w[SIZE_W-1:0];
		end
		ex_d = (ex_w < -24'sd32768) ? -16'sd32768 : ex_w[OUT_W-1:0];
		sy_d = sy_w[OUT_W-1] ? '0 : sy_w[SIZE_W-1:0];
		ey_d = ey_w;

		if (col_s1 > 23'sd32767) begin
			col_o = 16'sd32767;
		end else if (col_s1 < -23'sd32768) begin
			col_o = -16'sd32768;
		end else begin
			col_o = col_s1[OUT_W-1:0];
		end

		if (ty_s1 > 48'sd32767) begin
			depth_d = 16'sd32767;
		end else if (ty_s1 < -48'sd32768) begin
			depth_d = -16'sd32768;
		end else begin
			depth_d = ty_s1[OUT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			dist_q   <= dist_s1;
			depth_q  <= depth_d;
			behind_q <= behind_s1;
			col_q    <= behind_s1 ? '0 : col_o;
			size_q   <= behind_s1 ? '0 : size_s1;
			sx_q     <= behind_s1 ? '0 : sx_d;
			ex_q     <= behind_s1 ? '0 : ex_d;
			sy_q     <= behind_s1 ? '0 : sy_d;
			ey_q     <= behind_s1 ? '0 : ey_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign dist_sq       = dist_q;
	assign depth         = depth_q;
	assign behind_camera = behind_q;
	assign screen_col    = col_q;
	assign sprite_size   = size_q;
	assign draw_start_x  = sx_q;
	assign draw_end_x    = ex_q;
	assign draw_start_y  = sy_q;
	assign draw_end_y    = ey_q;

endmodule
`default_nettype wire
